FILE: hw/rtl/pcpf_pkg.sv
package pcpf_pkg;

    localparam int MaxSide = 4096;
    localparam int SideW   = $clog2(MaxSide + 1);
    localparam int PosW    = 12;
    localparam int DistW   = SideW + 1;
    localparam int SqW     = 2 * DistW + 1;
    localparam int RootW   = (SqW + 1) / 2;
    localparam int ChW     = 8;

    typedef enum logic [2:0] {
        MODE_VIGNETTE = 3'd0,
        MODE_CLARENDON = 3'd1,
        MODE_GRAY = 3'd2,
        MODE_CONTRAST = 3'd3,
        MODE_LIGHTEN = 3'd4,
        MODE_DARKEN = 3'd5,
        MODE_FIVE = 3'd6,
        MODE_PASS = 3'd7
    } t_mode;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_FACTOR = 2'd1;
    localparam logic [1:0] REG_ROWS   = 2'd2;
    localparam logic [1:0] REG_COLS   = 2'd3;

    typedef struct packed {
        t_mode             mode;
        logic [15:0]       factor;
        logic [SideW-1:0]  rows;
        logic [SideW-1:0]  cols;
    } t_cfg;

    typedef logic [ChW-1:0] t_px [3];

endpackage

FILE: hw/rtl/pcpf_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module pcpf_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [pcpf_pkg::SqW-1:0]   i_sq,
    output logic [pcpf_pkg::RootW-1:0] o_root
);
    import pcpf_pkg::*;

    localparam int Steps = RootW;
    localparam int RemW  = RootW + 2;

    logic [2*Steps-1:0] r_x   [Steps+1];
    logic [RemW-1:0]    r_rem [Steps+1];
    logic [RootW-1:0]   r_q   [Steps+1];

    always_comb begin
        r_x[0]   = {{(2*Steps-SqW){1'b0}}, i_sq};
        r_rem[0] = '0;
        r_q[0]   = '0;
    end

    genvar k;
    generate
        for (k = 0; k < Steps; k++) begin : g_step
            logic [RemW-1:0]  n_trial;
            logic [RemW-1:0]  n_cur;
            always_comb begin
                n_cur   = {r_rem[k][RemW-3:0], r_x[k][2*Steps-1 -: 2]};
                n_trial = {r_q[k], 2'b01};
            end
            // advance one root bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k+1] <= {r_x[k][2*Steps-3:0], 2'b00};
                    if (n_cur >= n_trial) begin
                        r_rem[k+1] <= n_cur - n_trial;
                        r_q[k+1]   <= {r_q[k][RootW-2:0], 1'b1};
                    end else begin
                        r_rem[k+1] <= n_cur;
                        r_q[k+1]   <= {r_q[k][RootW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_q[Steps];
endmodule

FILE: hw/rtl/pcpf_vdiv.sv
// Pipelined restoring divide: floor(num / den), one quotient bit per stage.
module pcpf_vdiv (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [pcpf_pkg::ChW+pcpf_pkg::SideW-1:0] i_num,
    input  logic [pcpf_pkg::SideW-1:0] i_den,
    output logic [pcpf_pkg::ChW-1:0] o_quo
);
    import pcpf_pkg::*;

    localparam int NumW = ChW + SideW;

    logic [NumW-1:0]   r_n [ChW+1];
    logic [SideW:0]    r_r [ChW+1];
    logic [SideW-1:0]  r_d [ChW+1];
    logic [ChW-1:0]    r_qq[ChW+1];

    // numerator < den << 8 so the top SideW bits give a remainder < den
    always_comb begin
        r_n[0]  = i_num;
        r_r[0]  = {1'b0, i_num[NumW-1 -: SideW]};
        r_d[0]  = i_den;
        r_qq[0] = '0;
    end

    genvar k;
    generate
        for (k = 0; k < ChW; k++) begin : g_bit
            logic [SideW+1:0] n_cur;
            always_comb n_cur = {r_r[k], r_n[k][ChW-1-k]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k+1] <= r_n[k];
                    r_d[k+1] <= r_d[k];
                    if (n_cur >= {2'b00, r_d[k]}) begin
                        r_r[k+1]  <= {1'b0, SideW'(n_cur - {2'b00, r_d[k]})};
                        r_qq[k+1] <= {r_qq[k][ChW-2:0], 1'b1};
                    end else begin
                        r_r[k+1]  <= {1'b0, SideW'(n_cur)};
                        r_qq[k+1] <= {r_qq[k][ChW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_qq[ChW];
endmodule

FILE: hw/rtl/pixel_color_point_filter_unit.sv
// Channel | dir | handshake             | payload
// pixel   | in  | i_valid / o_stall     | i_in_red/green/blue, i_pixel_row/col
// result  | out | o_valid / i_stall     | o_out_red/green/blue
// config  | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// One pixel per clock while the output is not stalled; the pipeline has LAT stages,
// set by the bit-per-stage square root and vignette divider.
// Reset (sync, low) clears valid bits and restores register defaults.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module pixel_color_point_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [11:0] i_pixel_row,
    input  logic [11:0] i_pixel_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pcpf_pkg::*;

    localparam int LS = RootW;          // stages in the root
    localparam int LD = ChW;            // stages in the divider
    localparam int LAT = 1 + LS + 1 + LD;

    t_cfg r_cfg;
    logic en;
    logic [LAT-1:0] r_vld;

    assign en          = !(r_vld[LAT-1] && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    // write config registers, clamping sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_GRAY;
            r_cfg.factor <= 16'd256;
            r_cfg.rows   <= SideW'(512);
            r_cfg.cols   <= SideW'(512);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_cfg.mode <= t_mode'(i_cfg_data[2:0]);
                REG_FACTOR: r_cfg.factor <= i_cfg_data;
                REG_ROWS:   r_cfg.rows <= (i_cfg_data[12:0] > 13'(MaxSide)) ?
                                SideW'(MaxSide) : SideW'(i_cfg_data[12:0]);
                REG_COLS:   r_cfg.cols <= (i_cfg_data[12:0] > 13'(MaxSide)) ?
                                SideW'(MaxSide) : SideW'(i_cfg_data[12:0]);
                default: ;
            endcase
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // stage 0: squared distance and point ops
    logic signed [SqW-1:0] dr, dc;
    logic [SqW-1:0] r_sq;
    t_px r_pt;
    t_px n_pt;
    logic [9:0] sum;
    logic [7:0] avg;
    logic [8:0] lt [3];
    logic [7:0] dk [3];
    logic [7:0] cin [3];

    assign cin[0] = i_in_red;
    assign cin[1] = i_in_green;
    assign cin[2] = i_in_blue;
    assign sum = 10'(i_in_red) + 10'(i_in_green) + 10'(i_in_blue);
    assign avg = 8'((20'(sum) * 20'd683) >> 11);

    always_comb begin
        logic [23:0] p;
        logic [23:0] q;
        for (int i = 0; i < 3; i++) begin
            p = 24'(8'd255 - cin[i]) * 24'(r_cfg.factor);
            p = (p + 24'd255) >> 8;
            lt[i] = (p >= 24'd255) ? 9'd0 : 9'(24'd255 - p);
            q = (24'(cin[i]) * 24'(r_cfg.factor)) >> 8;
            dk[i] = (q > 24'd255) ? 8'd255 : q[7:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n_pt[i] = cin[i];
        case (r_cfg.mode)
            MODE_CLARENDON: begin
                if (avg >= 8'd170) for (int i = 0; i < 3; i++) n_pt[i] = lt[i][7:0];
                else if (avg < 8'd90) for (int i = 0; i < 3; i++) n_pt[i] = dk[i];
            end
            MODE_GRAY: for (int i = 0; i < 3; i++) n_pt[i] = avg;
            MODE_CONTRAST:
                for (int i = 0; i < 3; i++) n_pt[i] = (avg >= 8'd127) ? 8'd255 : 8'd0;
            MODE_LIGHTEN: for (int i = 0; i < 3; i++) n_pt[i] = lt[i][7:0];
            MODE_DARKEN:  for (int i = 0; i < 3; i++) n_pt[i] = dk[i];
            MODE_FIVE: begin
                for (int i = 0; i < 3; i++) n_pt[i] = 8'd0;
                if (sum >= 10'd550) for (int i = 0; i < 3; i++) n_pt[i] = 8'd255;
                else if (sum <= 10'd150) ;
                else if (i_in_red >= i_in_green && i_in_red >= i_in_blue) n_pt[0] = 8'd255;
                else if (i_in_green >= i_in_blue) n_pt[1] = 8'd255;
                else n_pt[2] = 8'd255;
            end
            default: ;
        endcase
    end

    assign dr = $signed({2'b00, i_pixel_row}) - $signed({1'b0, r_cfg.rows >> 1});
    assign dc = $signed({2'b00, i_pixel_col}) - $signed({1'b0, r_cfg.cols >> 1});

    logic [7:0] r_ch0 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= $unsigned(dr * dr) + $unsigned(dc * dc);
            r_pt  <= n_pt;
            r_ch0 <= cin;
        end
    end

    // delay pixel data alongside the root and the divider
    t_px r_ptd [LS+1+LD];
    logic [7:0] r_chd [LS][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ptd[0] <= r_pt;
            for (int k = 1; k < LS + 1 + LD; k++) r_ptd[k] <= r_ptd[k-1];
            r_chd[0] <= r_ch0;
            for (int k = 1; k < LS; k++) r_chd[k] <= r_chd[k-1];
        end
    end

    logic [RootW-1:0] root;
    pcpf_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_sq(r_sq), .o_root(root)
    );

    // stage after root: numerators v*(R-d)
    logic [ChW+SideW-1:0] r_num [3];
    logic r_zero;
    logic [SideW-1:0] diff;
    assign diff = r_cfg.rows - SideW'(root);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= (RootW'(r_cfg.rows) <= root) || (r_cfg.rows == '0);
            for (int i = 0; i < 3; i++)
                r_num[i] <= (ChW+SideW)'(r_chd[LS-1][i] * diff);
        end
    end

    logic [LD-1:0] r_zd;
    always_ff @(posedge i_clk) if (en) r_zd <= {r_zd[LD-2:0], r_zero};

    logic [7:0] quo [3];
    logic [SideW-1:0] den;
    assign den = (r_cfg.rows == '0) ? SideW'(1) : r_cfg.rows;
    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_div
            pcpf_vdiv u_div (
                .i_clk(i_clk), .i_en(en), .i_num(r_zero ? '0 : r_num[c]),
                .i_den(den), .o_quo(quo[c])
            );
        end
    endgenerate

    t_px out_px;
    always_comb begin
        for (int i = 0; i < 3; i++)
            out_px[i] = (r_cfg.mode == MODE_VIGNETTE) ? (r_zd[LD-1] ? 8'd0 : quo[i])
                                                     : r_ptd[LS+LD][i];
    end
    assign o_out_red   = out_px[0];
    assign o_out_green = out_px[1];
    assign o_out_blue  = out_px[2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result lost while stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> r_vld[0] == $past(i_valid)) else $error("valid not advanced");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without pending result");
endmodule

FILE: sim/pcpf_checker.sv
module pcpf_checker
    import pcpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [11:0] i_pixel_row,
    input  logic [11:0] i_pixel_col,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_red,
    input  logic [7:0]  i_out_green,
    input  logic [7:0]  i_out_blue,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    t_mode       mode_q;
    logic [15:0] factor_q;
    logic [12:0] rows_q;
    logic [12:0] cols_q;
    t_rgb        expected_px[$];

    function automatic logic [31:0] int_sqrt(input logic [31:0] x);
        logic [31:0] res;
        logic [31:0] bitv;
        res  = 0;
        bitv = 32'h4000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] brighten(input logic [7:0] v);
        logic [31:0] up;
        up = ((32'(8'd255 - v) * factor_q) + 32'd255) >> 8;
        return (up >= 255) ? 8'd0 : 8'(255 - up);
    endfunction

    function automatic logic [7:0] dim(input logic [7:0] v);
        logic [31:0] p;
        p = (32'(v) * factor_q) >> 8;
        return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function automatic t_rgb filter_pixel(input t_rgb px, input logic [11:0] row,
                                          input logic [11:0] col);
        logic [9:0]  sum;
        logic [7:0]  avg;
        logic [7:0]  mx;
        logic [12:0] rows;
        logic [12:0] cols;
        int          dr;
        int          dc;
        logic [31:0] radius;
        t_rgb        o;
        sum = 10'(px.red) + 10'(px.green) + 10'(px.blue);
        avg = 8'(sum / 3);
        o   = px;
        case (mode_q)
            MODE_VIGNETTE: begin
                rows = (rows_q > MaxSide) ? 13'(MaxSide) : rows_q;
                cols = (cols_q > MaxSide) ? 13'(MaxSide) : cols_q;
                dr   = int'(row) - int'(rows / 2);
                dc   = int'(col) - int'(cols / 2);
                radius = int_sqrt(32'(dr * dr + dc * dc));
                if (radius >= rows) begin
                    o = '0;
                end else begin
                    o.red   = 8'((32'(px.red) * (rows - radius)) / rows);
                    o.green = 8'((32'(px.green) * (rows - radius)) / rows);
                    o.blue  = 8'((32'(px.blue) * (rows - radius)) / rows);
                end
            end
            MODE_CLARENDON: begin
                if (avg >= 170) o = '{brighten(px.red), brighten(px.green), brighten(px.blue)};
                else if (avg < 90) o = '{dim(px.red), dim(px.green), dim(px.blue)};
            end
            MODE_GRAY:     o = '{avg, avg, avg};
            MODE_CONTRAST: o = (avg >= 127) ? '1 : '0;
            MODE_LIGHTEN:  o = '{brighten(px.red), brighten(px.green), brighten(px.blue)};
            MODE_DARKEN:   o = '{dim(px.red), dim(px.green), dim(px.blue)};
            MODE_FIVE: begin
                mx = px.red;
                if (px.green > mx) mx = px.green;
                if (px.blue > mx) mx = px.blue;
                if (sum >= 550) o = '{8'd255, 8'd255, 8'd255};
                else if (sum <= 150) o = '0;
                else if (mx == px.red) o = '{8'd255, 8'd0, 8'd0};
                else if (mx == px.green) o = '{8'd0, 8'd255, 8'd0};
                else o = '{8'd0, 8'd0, 8'd255};
            end
            default: o = px;
        endcase
        return o;
    endfunction

    assign o_pending = expected_px.size();

    // Track registers, predict accepted pixels, compare result beats
    always @(posedge i_clk) begin
        t_rgb want;
        if (!i_rst_n) begin
            mode_q   <= MODE_GRAY;
            factor_q <= 16'd256;
            rows_q   <= 13'd512;
            cols_q   <= 13'd512;
            expected_px.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:   mode_q   <= t_mode'(i_cfg_data[2:0]);
                    REG_FACTOR: factor_q <= i_cfg_data;
                    REG_ROWS:   rows_q   <= i_cfg_data[12:0];
                    REG_COLS:   cols_q   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                expected_px.push_back(filter_pixel({i_in_red, i_in_green, i_in_blue},
                                                   i_pixel_row, i_pixel_col));
            if (i_out_valid && !i_out_stall) begin
                if (expected_px.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result beat %h %h %h",
                                                i_out_red, i_out_green, i_out_blue);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_px.pop_front();
                    if (want != {i_out_red, i_out_green, i_out_blue}) begin
                        if (o_errors < 10)
                            $display("mismatch: expected r%0d g%0d b%0d got r%0d g%0d b%0d",
                                     want.red, want.green, want.blue,
                                     i_out_red, i_out_green, i_out_blue);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
module tb;
    import pcpf_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_red;
    logic [7:0]  i_in_green;
    logic [7:0]  i_in_blue;
    logic [11:0] i_pixel_row;
    logic [11:0] i_pixel_col;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          quiet_cycles;

    pixel_color_point_filter_unit u_top (.*);

    pcpf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_in_red(i_in_red), .i_in_green(i_in_green), .i_in_blue(i_in_blue),
        .i_pixel_row(i_pixel_row), .i_pixel_col(i_pixel_col),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_red(o_out_red), .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(mismatches), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_filter(input t_mode mode, input logic [15:0] factor,
                              input logic [15:0] rows, input logic [15:0] cols);
        write_reg(REG_MODE, 16'(mode));
        write_reg(REG_FACTOR, factor);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    // Present one pixel beat, with optional leading gaps
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [11:0] row, input logic [11:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_red    <= r;
        i_in_green  <= g;
        i_in_blue   <= b;
        i_pixel_row <= row;
        i_pixel_col <= col;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Let the pipeline empty before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic random_pixel();
        logic [11:0] row;
        logic [11:0] col;
        row = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(80));
        col = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(80));
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), row, col);
    endtask

    task automatic random_phase(input int count);
        t_mode       mode;
        logic [15:0] factor;
        logic [15:0] rows;
        logic [15:0] cols;
        mode = t_mode'($urandom_range(7));
        case ($urandom_range(3))
            0: factor = 16'($urandom);
            1: factor = 16'hFFFF;
            2: factor = 16'd0;
            default: factor = 16'($urandom_range(512));
        endcase
        case ($urandom_range(5))
            0: rows = 16'd0;
            1: rows = 16'h1FFF;
            2: rows = 16'(MaxSide);
            3: rows = 16'($urandom);
            default: rows = 16'($urandom_range(1, 160));
        endcase
        cols = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(1, 160));
        set_filter(mode, factor, rows, cols);
        repeat (count) random_pixel();
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_red      = '0;
        i_in_green    = '0;
        i_in_blue     = '0;
        i_pixel_row   = '0;
        i_pixel_col   = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, then every mode at field extremes
        send_pixel(8'd10, 8'd20, 8'd255, 12'd0, 12'd0);
        drain();
        for (int m = 0; m < 8; m++) begin
            set_filter(t_mode'(m), (m == 5) ? 16'hFFFF : 16'd384, 16'd64, 16'd64);
            send_pixel(8'd0, 8'd0, 8'd0, 12'd32, 12'd32);
            send_pixel(8'd255, 8'd255, 8'd255, 12'hFFF, 12'hFFF);
            send_pixel(8'd200, 8'd170, 8'd180, 12'd0, 12'd63);
            drain();
        end
        // Zero rows and oversized sides in vignette
        set_filter(MODE_VIGNETTE, 16'd0, 16'd0, 16'h1FFF);
        send_pixel(8'd255, 8'd128, 8'd1, 12'd5, 12'd5);
        drain();
        write_reg(REG_ROWS, 16'h1FFF);
        send_pixel(8'd255, 8'd255, 8'd255, 12'd2048, 12'd2048);
        send_pixel(8'd255, 8'd255, 8'd255, 12'd0, 12'hFFF);
        drain();

        // Random phases under three idling profiles
        for (int p = 0; p < 3; p++) begin
            send_idle_pct  = (p == 0) ? 11 : (p == 1) ? 85 : 0;
            recv_stall_pct = (p == 0) ? 85 : (p == 1) ? 11 : 0;
            for (int k = 0; k < 6; k++) random_phase((p == 1) ? 30 : 60);
        end

        // Long receiver hold-off while pixels keep coming
        set_filter(MODE_DARKEN, 16'd300, 16'd100, 16'd100);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (90) random_pixel();
        join
        drain();

        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
